[design/esc_pkg.sv]
package esc_pkg;

    localparam int unsigned ALU_W   = 18;
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 26;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // Divisors for the multiply-back that gives each remainder
    localparam logic [MUL_B_W-1:0] SEC_PER_DAY  = MUL_B_W'(86400);
    localparam logic [MUL_B_W-1:0] SEC_PER_HOUR = MUL_B_W'(3600);
    localparam logic [MUL_B_W-1:0] SEC_PER_MIN  = MUL_B_W'(60);
    localparam logic [MUL_B_W-1:0] DAYS_PER_WK  = MUL_B_W'(7);

    // Rounded-up reciprocals; (x * RCP) >> shift is the exact quotient over the
    // full range of x. The power-of-two part of the divisor is shifted off first.
    localparam logic [MUL_B_W-1:0] RCP_DAY  = MUL_B_W'(50903317); // 2^35 / 675, t >> 7
    localparam logic [MUL_B_W-1:0] RCP_HOUR = MUL_B_W'(9321);     // 2^21 / 225, secs >> 4
    localparam logic [MUL_B_W-1:0] RCP_MIN  = MUL_B_W'(1093);     // 2^14 / 15, rem >> 2
    localparam logic [MUL_B_W-1:0] RCP_WDAY = MUL_B_W'(74899);    // 2^19 / 7

    localparam logic [ALU_W-1:0] DAYS_NORMAL = ALU_W'(365);
    localparam logic [ALU_W-1:0] DAYS_LEAP   = ALU_W'(366);

    localparam logic [7:0]  EPOCH_YEAR_OFS = 8'd70;   // 1970 - 1900
    localparam logic [7:0]  YEAR_2100_OFS  = 8'd200;  // only non-leap century in range
    localparam logic [15:0] EPOCH_WEEKDAY  = 16'd4;   // Thursday
    localparam logic [3:0]  LAST_MONTH     = 4'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_Q,
        ST_DAY_R,
        ST_HOUR_Q,
        ST_HOUR_R,
        ST_MIN_Q,
        ST_MIN_R,
        ST_WDAY_Q,
        ST_WDAY_R,
        ST_YEAR,
        ST_MONTH
    } esc_state_t;

    // Output of the shared subtract/compare unit
    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             ge;
    } sub_res_t;

    // y is the year minus 1900, valid for 70..206
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_2100_OFS);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd3:    d = 5'd30;
            4'd5:    d = 5'd30;
            4'd8:    d = 5'd30;
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

[design/esc_sub.sv]
module esc_sub
    import esc_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output sub_res_t         res
);

    logic [ALU_W:0] wide;

    assign wide     = {1'b0, a} - {1'b0, b};
    assign res.diff = wide[ALU_W-1:0];
    assign res.ge   = ~wide[ALU_W];

endmodule

[design/epoch_seconds_to_calendar.sv]
// Epoch seconds to UTC calendar time.
//
// Request channel: req_valid / req_stall carry epoch_seconds, an unsigned
// count of seconds since 1970-01-01 00:00:00 UTC. A transfer happens on a
// rising edge with req_valid high and req_stall low. req_stall is high the
// whole time a conversion is in flight; one item is worked at a time.
// Response channel: rsp_valid / rsp_stall carry second, minute, hour,
// weekday (0 = Sunday), years_since_1900, day_of_year, month (0 = Jan) and
// day_of_month (from 1). Results sit in an output register, so a new
// request is taken while the previous result still waits for its transfer.
// Sequence: four constant divisions (day, hour, minute, weekday), each a
// reciprocal multiply for the quotient and then a multiply-back and
// subtract for the remainder; then a walk over the years from 1970 and a
// walk over the months, each taking off one year's or month's days per
// step. The year walk dominates. The next request is taken the cycle after
// a result is handed over. If rsp_stall holds a result, a finished
// conversion waits in its last state until the output register frees up.
// Reset clears the sequencer and rsp_valid; no result is pending after it.
module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [31:0] epoch_seconds,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [7:0]  years_since_1900,
    output logic [8:0]  day_of_year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month
);

    esc_state_t state_reg, state_next;

    // Working registers: num holds the dividend, quo the quotient just found
    logic [31:0]      num_reg, num_next;
    logic [15:0]      quo_reg, quo_next;
    logic [ALU_W-1:0] rem_reg, rem_next;
    logic [15:0]      days_reg, days_next;
    logic [7:0]       year_reg, year_next;
    logic [3:0]       mon_reg, mon_next;
    logic [4:0]       hour_reg, hour_next;
    logic [5:0]       min_reg, min_next;
    logic [5:0]       sec_reg, sec_next;
    logic [2:0]       wday_reg, wday_next;
    logic [8:0]       yday_reg, yday_next;

    // Output register
    logic             rsp_valid_reg, rsp_valid_next;
    logic [5:0]       o_sec_reg, o_sec_next;
    logic [5:0]       o_min_reg, o_min_next;
    logic [4:0]       o_hour_reg, o_hour_next;
    logic [2:0]       o_wday_reg, o_wday_next;
    logic [7:0]       o_year_reg, o_year_next;
    logic [8:0]       o_yday_reg, o_yday_next;
    logic [3:0]       o_mon_reg, o_mon_next;
    logic [4:0]       o_mday_reg, o_mday_next;

    // Shared unit operands
    logic [ALU_W-1:0]   alu_a, alu_b;
    sub_res_t           alu_res;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic               leap;

    esc_sub u_sub (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // Shared multiplier: reciprocal products and multiply-backs
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign leap = is_leap(year_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            ST_DAY_Q:
            begin
                mul_a = num_reg[31:7];
                mul_b = RCP_DAY;
            end
            ST_HOUR_Q:
            begin
                mul_a = MUL_A_W'(num_reg[16:4]);
                mul_b = RCP_HOUR;
            end
            ST_MIN_Q:
            begin
                mul_a = MUL_A_W'(num_reg[11:2]);
                mul_b = RCP_MIN;
            end
            ST_WDAY_Q:
            begin
                mul_a = MUL_A_W'(num_reg[15:0]);
                mul_b = RCP_WDAY;
            end
            ST_DAY_R:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = SEC_PER_DAY;
                alu_a = num_reg[ALU_W-1:0];
                alu_b = prod[ALU_W-1:0];
            end
            ST_HOUR_R:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = SEC_PER_HOUR;
                alu_a = num_reg[ALU_W-1:0];
                alu_b = prod[ALU_W-1:0];
            end
            ST_MIN_R:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = SEC_PER_MIN;
                alu_a = num_reg[ALU_W-1:0];
                alu_b = prod[ALU_W-1:0];
            end
            ST_WDAY_R:
            begin
                mul_a = MUL_A_W'(quo_reg);
                mul_b = DAYS_PER_WK;
                alu_a = num_reg[ALU_W-1:0];
                alu_b = prod[ALU_W-1:0];
            end
            ST_YEAR:
            begin
                alu_a = rem_reg;
                alu_b = leap ? DAYS_LEAP : DAYS_NORMAL;
            end
            ST_MONTH:
            begin
                alu_a = rem_reg;
                alu_b = ALU_W'(month_days(mon_reg, leap));
            end
            default:
            begin
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        days_next      = days_reg;
        year_next      = year_reg;
        mon_next       = mon_reg;
        hour_next      = hour_reg;
        min_next       = min_reg;
        sec_next       = sec_reg;
        wday_next      = wday_reg;
        yday_next      = yday_reg;
        rsp_valid_next = rsp_valid_reg;
        o_sec_next     = o_sec_reg;
        o_min_next     = o_min_reg;
        o_hour_next    = o_hour_reg;
        o_wday_next    = o_wday_reg;
        o_year_next    = o_year_reg;
        o_yday_next    = o_yday_reg;
        o_mon_next     = o_mon_reg;
        o_mday_next    = o_mday_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    num_next   = epoch_seconds;
                    state_next = ST_DAY_Q;
                end
            end

            // quotient = product >> (reciprocal shift); remainder below by
            // multiply-back and subtract, exact in the low ALU_W bits
            ST_DAY_Q:
            begin
                quo_next   = prod[50:35];
                state_next = ST_DAY_R;
            end
            ST_DAY_R:
            begin
                days_next  = quo_reg;
                num_next   = {15'd0, alu_res.diff[16:0]};  // seconds of the day
                state_next = ST_HOUR_Q;
            end
            ST_HOUR_Q:
            begin
                quo_next   = prod[36:21];
                state_next = ST_HOUR_R;
            end
            ST_HOUR_R:
            begin
                hour_next  = quo_reg[4:0];
                num_next   = {20'd0, alu_res.diff[11:0]};  // seconds of the hour
                state_next = ST_MIN_Q;
            end
            ST_MIN_Q:
            begin
                quo_next   = prod[29:14];
                state_next = ST_MIN_R;
            end
            ST_MIN_R:
            begin
                min_next   = quo_reg[5:0];
                sec_next   = alu_res.diff[5:0];
                num_next   = {16'd0, days_reg + EPOCH_WEEKDAY};
                state_next = ST_WDAY_Q;
            end
            ST_WDAY_Q:
            begin
                quo_next   = prod[34:19];
                state_next = ST_WDAY_R;
            end
            ST_WDAY_R:
            begin
                wday_next  = alu_res.diff[2:0];
                rem_next   = {2'b00, days_reg};
                year_next  = EPOCH_YEAR_OFS;
                state_next = ST_YEAR;
            end

            ST_YEAR:
            begin
                if (alu_res.ge)
                begin
                    rem_next  = alu_res.diff;
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    yday_next  = rem_reg[8:0];
                    mon_next   = '0;
                    state_next = ST_MONTH;
                end
            end

            ST_MONTH:
            begin
                if (mon_reg != LAST_MONTH && alu_res.ge)
                begin
                    rem_next = alu_res.diff;
                    mon_next = mon_reg + 4'd1;
                end
                else if (!(rsp_valid_reg && rsp_stall))
                begin
                    // hand over to the output register
                    rsp_valid_next = 1'b1;
                    o_sec_next     = sec_reg;
                    o_min_next     = min_reg;
                    o_hour_next    = hour_reg;
                    o_wday_next    = wday_reg;
                    o_year_next    = year_reg;
                    o_yday_next    = yday_reg;
                    o_mon_next     = mon_reg;
                    o_mday_next    = rem_reg[4:0] + 5'd1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        sec_reg    <= sec_next;
        wday_reg   <= wday_next;
        yday_reg   <= yday_next;
        o_sec_reg  <= o_sec_next;
        o_min_reg  <= o_min_next;
        o_hour_reg <= o_hour_next;
        o_wday_reg <= o_wday_next;
        o_year_reg <= o_year_next;
        o_yday_reg <= o_yday_next;
        o_mon_reg  <= o_mon_next;
        o_mday_reg <= o_mday_next;
    end

    assign req_stall        = (state_reg != ST_IDLE);
    assign rsp_valid        = rsp_valid_reg;
    assign second           = o_sec_reg;
    assign minute           = o_min_reg;
    assign hour             = o_hour_reg;
    assign weekday          = o_wday_reg;
    assign years_since_1900 = o_year_reg;
    assign day_of_year      = o_yday_reg;
    assign month            = o_mon_reg;
    assign day_of_month     = o_mday_reg;

endmodule

[design/esc_chk.sv]
module esc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [5:0]  second,
    input logic [5:0]  minute,
    input logic [4:0]  hour,
    input logic [2:0]  weekday,
    input logic [8:0]  day_of_year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month
);

    // a held result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // after a request transfer the block is busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side not busy after transfer");

    // a new result only comes out of a running conversion
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without a conversion in flight");

    // fields of an offered result are in calendar range
    a_rsp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24)
                   && (weekday < 3'd7) && (month < 4'd12) && (day_of_year < 9'd366)
                   && (day_of_month != 5'd0))
        else $error("response field out of range");

endmodule

bind epoch_seconds_to_calendar esc_chk u_esc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .weekday      (weekday),
    .day_of_year  (day_of_year),
    .month        (month),
    .day_of_month (day_of_month)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

// Testbench for epoch_seconds_to_calendar.
//
// Stimulus starts with a directed set: the epoch, minute, hour and day edges,
// leap days, the year 2100 (a century that is not leap) and the 32-bit limit
// in early 2106. A random set follows, weighted toward year starts, the end of
// February and the ends of the 32-bit range, with a share of fully random counts.
// A clocked driver feeds request transfers from a queue. A clocked monitor
// checks each response transfer against the oldest predicted calendar entry.
// The run has four phases of sender idling and receiver stalling. Between
// phases the sender holds off until every predicted result has come back.
module tb_top;

    // Broken-down calendar time at the block's output widths
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month;
        logic [4:0] day_of_month;
    } cal_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [31:0] epoch_seconds = 32'd0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [7:0]  years_since_1900;
    logic [8:0]  day_of_year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;

    logic [31:0] epoch_pending_q[$];   // counts not yet offered to the block
    cal_t        cal_expect_q[$];      // predicted calendar times, oldest first

    int unsigned send_idle_pct = 0;    // chance per cycle the sender goes idle
    int unsigned rsp_stall_pct = 0;    // chance per cycle the receiver stalls
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;

    epoch_seconds_to_calendar dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .epoch_seconds    (epoch_seconds),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .weekday          (weekday),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .month            (month),
        .day_of_month     (day_of_month)
    );

    always #10 clk = ~clk;

    // Gregorian rule on the full year number
    function automatic bit leap_year(int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned year_len(int unsigned yr);
        return leap_year(yr) ? 366 : 365;
    endfunction

    function automatic int unsigned month_len(int unsigned yr, int unsigned mo);
        int unsigned d;
        case (mo)
            1:       d = leap_year(yr) ? 29 : 28;
            3, 5, 8, 10: d = 30;
            default: d = 31;
        endcase
        return d;
    endfunction

    // Days from 1970-01-01 to January 1 of yr
    function automatic longint days_to_year(int unsigned yr);
        longint d;
        d = 0;
        for (int unsigned y = 1970; y < yr; y++)
            d += year_len(y);
        return d;
    endfunction

    // Seconds count for a given year, day of year and second of day
    function automatic logic [31:0] epoch_of(int unsigned yr, int unsigned yday,
                                             int unsigned sod);
        longint v;
        v = (days_to_year(yr) + yday) * 86400 + sod;
        return v[31:0];
    endfunction

    // Expected calendar time: split off the day, walk years, then months
    function automatic cal_t predict_calendar(logic [31:0] t);
        cal_t        r;
        int unsigned secs;
        int unsigned days;
        int unsigned yr;
        int unsigned mo;
        secs = t % 86400;
        days = t / 86400;
        r.second  = 6'(secs % 60);
        r.minute  = 6'((secs % 3600) / 60);
        r.hour    = 5'(secs / 3600);
        r.weekday = 3'((days + 4) % 7);       // the epoch fell on a Thursday
        yr = 1970;
        while (days >= year_len(yr)) begin
            days -= year_len(yr);
            yr++;
        end
        r.day_of_year = 9'(days);
        mo = 0;
        while (mo < 11 && days >= month_len(yr, mo)) begin
            days -= month_len(yr, mo);
            mo++;
        end
        r.years_since_1900 = 8'(yr - 1900);
        r.month            = 4'(mo);
        r.day_of_month     = 5'(days + 1);
        return r;
    endfunction

    // Random count, mostly near year starts, the end of February and the range ends
    function automatic logic [31:0] random_epoch();
        longint      v;
        int unsigned kind;
        int unsigned yr;
        kind = $urandom_range(0, 9);
        yr   = $urandom_range(1970, 2106);
        case (kind)
            0, 1, 2: v = $urandom;
            3, 4, 5: v = days_to_year(yr) * 86400
                         + longint'($urandom_range(0, 180000)) - 90000;
            6, 7:    v = (days_to_year(yr) + $urandom_range(55, 62)) * 86400
                         + $urandom_range(0, 86399);
            8:       v = (days_to_year(yr) + $urandom_range(0, 365)) * 86400
                         + $urandom_range(0, 86399);
            default: v = $urandom_range(0, 1) ? longint'($urandom_range(0, 200000))
                         : 64'hFFFF_FFFF - $urandom_range(0, 200000);
        endcase
        // out of the 32-bit range (late 2106 or before the epoch)
        if (v < 0 || v > 64'hFFFF_FFFF)
            v = $urandom;
        return v[31:0];
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            n_errors++;
        end
    endtask

    // Driver: a stalled payload is held; otherwise pick idle or the next count.
    // One nonblocking write to req_valid per edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end
        else begin
            if (req_valid && !req_stall) begin
                cal_expect_q.push_back(predict_calendar(epoch_seconds));
                n_sent++;
            end
            if (!req_valid || !req_stall) begin
                if (epoch_pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_valid     <= 1'b1;
                    epoch_seconds <= epoch_pending_q.pop_front();
                end
                else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each response transfer, then choose the next stall
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end
        else begin
            if (rsp_valid && !rsp_stall) begin
                if (cal_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d/%0d/%0d %0d:%0d:%0d",
                             $time, years_since_1900, month, day_of_month,
                             hour, minute, second);
                    n_errors++;
                end
                else begin
                    cal_t exp_c;
                    exp_c = cal_expect_q.pop_front();
                    check_field("second", exp_c.second, second);
                    check_field("minute", exp_c.minute, minute);
                    check_field("hour", exp_c.hour, hour);
                    check_field("weekday", exp_c.weekday, weekday);
                    check_field("years_since_1900", exp_c.years_since_1900, years_since_1900);
                    check_field("day_of_year", exp_c.day_of_year, day_of_year);
                    check_field("month", exp_c.month, month);
                    check_field("day_of_month", exp_c.day_of_month, day_of_month);
                    n_checked++;
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
        end
    end

    // Sender holds off until the queue, the request port and all predictions
    // are empty; the block keeps nothing else in flight.
    task automatic drain();
        while (epoch_pending_q.size() > 0 || req_valid || cal_expect_q.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned hold_pct,
                             int unsigned n_items);
        send_idle_pct = idle_pct;
        rsp_stall_pct = hold_pct;
        repeat (n_items)
            epoch_pending_q.push_back(random_epoch());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: day edges, leap days, 2100, sign bit and the 2106 limit
        epoch_pending_q.push_back(32'd0);
        epoch_pending_q.push_back(32'd1);
        epoch_pending_q.push_back(32'd59);
        epoch_pending_q.push_back(32'd60);
        epoch_pending_q.push_back(32'd3599);
        epoch_pending_q.push_back(32'd3600);
        epoch_pending_q.push_back(32'd86399);
        epoch_pending_q.push_back(32'd86400);
        epoch_pending_q.push_back(epoch_of(1970, 364, 86399));
        epoch_pending_q.push_back(epoch_of(1972, 59, 0));      // Feb 29
        epoch_pending_q.push_back(epoch_of(1972, 365, 86399)); // last day of a leap year
        epoch_pending_q.push_back(epoch_of(2000, 59, 43200));  // leap century
        epoch_pending_q.push_back(epoch_of(2000, 365, 0));
        epoch_pending_q.push_back(epoch_of(2100, 58, 86399));  // Feb 28, no leap day
        epoch_pending_q.push_back(epoch_of(2100, 59, 0));      // Mar 1
        epoch_pending_q.push_back(epoch_of(2104, 59, 0));
        epoch_pending_q.push_back(32'h7FFF_FFFF);
        epoch_pending_q.push_back(32'h8000_0000);
        epoch_pending_q.push_back(32'h5555_5555);
        epoch_pending_q.push_back(32'hAAAA_AAAA);
        epoch_pending_q.push_back(32'hFFFF_FFFE);
        epoch_pending_q.push_back(32'hFFFF_FFFF);
        drain();

        run_phase(0, 0, 125);     // back to back
        run_phase(86, 0, 125);    // sparse requests
        run_phase(0, 86, 125);    // slow receiver
        run_phase(28, 28, 125);   // light idling on both sides

        // let any conversion still in flight finish
        repeat (300) @(negedge clk);
        if (cal_expect_q.size() != 0) begin
            $display("%0t: %0d results still expected, got none", $time, cal_expect_q.size());
            n_errors++;
        end

        $display("run: %0d request transfers, %0d results compared, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("run: epoch to 2106 limit, leap and 2100 edges, four idle/stall phases");
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: ends a run that hangs
    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[epoch_seconds_to_calendar.f]
design/esc_pkg.sv
design/esc_sub.sv
design/epoch_seconds_to_calendar.sv
design/esc_chk.sv
verif/tb_top.sv
